/* hdl/rvx_pkg.sv */
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared constants, types and controller/datapath interface structs for the
// RV32IM subset execute block.
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam int MEM_BYTES_DEF = 65536;

    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_SYS    = 7'h73;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_JAL    = 7'h6F;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_MUL  = 3'd0;
    localparam logic [2:0] F3_MULH = 3'd1;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_REM  = 3'd6;

    localparam logic [2:0] F3_BYTE = 3'd0;
    localparam logic [2:0] F3_HALF = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    localparam logic [31:0] SYS_PRINT = 32'd1;
    localparam logic [31:0] SYS_EXIT  = 32'd10;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_A0   = 5'd10;
    localparam logic [4:0] REG_A1   = 5'd11;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_INSN  = 3'd1;
    localparam logic [2:0] ERR_READ  = 3'd2;
    localparam logic [2:0] ERR_WRITE = 3'd3;
    localparam logic [2:0] ERR_ECALL = 3'd4;

    typedef enum logic [2:0] {
        CLS_SIMPLE,
        CLS_MUL,
        CLS_DIV,
        CLS_LOAD,
        CLS_STORE
    } cls_t;

    typedef struct packed {
        logic load_ir;
        logic exec;
        logic div_start;
        logic mem_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_busy;
        logic stopped;
        cls_t cls;
        logic exec_err;
        logic mem_last;
        logic div_done;
    } sts_t;

endpackage

/* hdl/rvx_div.sv */
// ----------------------------------------------------------------------------
// rvx_div
// Signed 32-bit radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rvx_div
    import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic [31:0] quotient,
    output logic [31:0] remainder,
    output logic        done
);

    localparam logic [4:0] STEP_LAST = 5'd31;

    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        negq_reg;
    logic        negr_reg;
    logic [32:0] shifted;
    logic [32:0] trial;

    assign shifted = {rem_reg[31:0], quo_reg[31]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == STEP_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Magnitudes are divided; signs are applied on the way out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_reg  <= divisor[31] ? (32'd0 - divisor) : divisor;
            negq_reg <= dividend[31] ^ divisor[31];
            negr_reg <= dividend[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign quotient  = negq_reg ? (32'd0 - quo_reg) : quo_reg;
    assign remainder = negr_reg ? (32'd0 - rem_reg[31:0]) : rem_reg[31:0];
    assign done      = done_reg;

endmodule

/* hdl/rvx_dpath.sv */
// ----------------------------------------------------------------------------
// rvx_dpath
// Datapath: instruction register, register file, ALU, multiplier, divider,
// byte-wide data memory with its clearing pass, and the result register.
// ----------------------------------------------------------------------------
module rvx_dpath
    import rvx_pkg::*;
#(
    parameter int MEMORY_BYTES = MEM_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [31:0]        instruction_word,
    output logic [31:0]        next_pc,
    output logic               print_valid,
    output logic signed [31:0] print_value,
    output logic               halted,
    output logic [2:0]         error_code
);

    localparam int          AW        = $clog2(MEMORY_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEMORY_BYTES - 1);
    localparam logic [32:0] MEM_LIMIT = 33'(MEMORY_BYTES);

    // Instruction fields
    logic [31:0] ir_reg;
    logic [6:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;

    assign op    = ir_reg[6:0];
    assign rd    = ir_reg[11:7];
    assign f3    = ir_reg[14:12];
    assign rs1   = ir_reg[19:15];
    assign rs2   = ir_reg[24:20];
    assign f7    = ir_reg[31:25];
    assign imm_i = {{20{ir_reg[31]}}, ir_reg[31:20]};
    assign imm_s = {{20{ir_reg[31]}}, ir_reg[31:25], ir_reg[11:7]};
    assign imm_b = {{19{ir_reg[31]}}, ir_reg[31], ir_reg[7], ir_reg[30:25],
                    ir_reg[11:8], 1'b0};
    assign imm_j = {{11{ir_reg[31]}}, ir_reg[31], ir_reg[19:12], ir_reg[20],
                    ir_reg[30:21], 1'b0};

    // Architectural state
    logic [31:0] pc_reg;
    logic        stopped_reg;

    // Register file with per-entry valid bits standing in for the reset clear
    logic [31:0] rf_mem [32];
    logic [31:0] rf_vld_reg;
    logic [31:0] rd1_reg;
    logic [31:0] rd2_reg;
    logic        rd1_vld_reg;
    logic        rd2_vld_reg;
    logic [4:0]  ra1;
    logic [4:0]  ra2;
    logic [31:0] a;
    logic [31:0] b;
    logic        wen;
    logic [31:0] wval;

    // ecall reads a0 and a1 through the same two ports.
    assign ra1 = (op == OP_SYS) ? REG_A0 : rs1;
    assign ra2 = (op == OP_SYS) ? REG_A1 : rs2;
    assign a   = rd1_vld_reg ? rd1_reg : 32'd0;
    assign b   = rd2_vld_reg ? rd2_reg : 32'd0;

    always_ff @(posedge clk)
    begin
        rd1_reg <= rf_mem[ra1];
        rd2_reg <= rf_mem[ra2];
        if (wen)
        begin
            rf_mem[rd] <= wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg  <= '0;
            rd1_vld_reg <= 1'b0;
            rd2_vld_reg <= 1'b0;
        end
        else
        begin
            rd1_vld_reg <= rf_vld_reg[ra1];
            rd2_vld_reg <= rf_vld_reg[ra2];
            if (wen)
            begin
                rf_vld_reg[rd] <= 1'b1;
            end
        end
    end

    // Execute stage logic
    logic [31:0] alu_b;
    logic [4:0]  shamt;
    logic [31:0] alu_val;
    logic        r_ok;
    logic        i_ok;
    logic [2:0]  mem_len;
    logic [31:0] mem_addr;
    logic        in_rng;
    logic [2:0]  e_err;
    logic        e_halt;
    logic        e_pv;
    logic        e_wr;
    logic [31:0] e_val;
    logic [31:0] e_npc;
    cls_t        e_cls;

    assign alu_b    = (op == OP_REG) ? b : imm_i;
    assign shamt    = alu_b[4:0];
    assign mem_len  = 3'd1 << f3[1:0];
    assign mem_addr = a + ((op == OP_STORE) ? imm_s : imm_i);
    assign in_rng   = (({1'b0, mem_addr} + 33'(mem_len)) <= MEM_LIMIT);

    assign r_ok = ((f7 == F7_BASE) && (f3 != F3_SLTU))
               || ((f7 == F7_ALT) && ((f3 == F3_ADD) || (f3 == F3_SR)))
               || ((f7 == F7_MULDIV) && ((f3 == F3_MUL) || (f3 == F3_MULH)
                                      || (f3 == F3_DIV) || (f3 == F3_REM)));
    assign i_ok = (f3 == F3_SLL) ? (f7 == F7_BASE)
                : (f3 == F3_SR)  ? ((f7 == F7_BASE) || (f7 == F7_ALT))
                : (f3 != F3_SLTU);

    always_comb
    begin
        unique case (f3)
            F3_ADD:  alu_val = ((op == OP_REG) && ir_reg[30]) ? (a - b) : (a + alu_b);
            F3_SLL:  alu_val = a << shamt;
            F3_SLT:  alu_val = {31'd0, ($signed(a) < $signed(alu_b))};
            F3_SLTU: alu_val = 32'd0;
            F3_XOR:  alu_val = a ^ alu_b;
            F3_SR:   alu_val = ir_reg[30] ? 32'($signed(a) >>> shamt) : (a >> shamt);
            F3_OR:   alu_val = a | alu_b;
            F3_AND:  alu_val = a & alu_b;
        endcase
    end

    always_comb
    begin
        e_err  = ERR_NONE;
        e_halt = 1'b0;
        e_pv   = 1'b0;
        e_wr   = 1'b0;
        e_val  = alu_val;
        e_npc  = pc_reg + 32'd4;
        e_cls  = CLS_SIMPLE;
        unique case (op)
            OP_REG:
            begin
                e_wr = 1'b1;
                if (!r_ok)
                begin
                    e_err = ERR_INSN;
                end
                if (f7 == F7_MULDIV)
                begin
                    e_cls = ((f3 == F3_DIV) || (f3 == F3_REM)) ? CLS_DIV : CLS_MUL;
                end
            end
            OP_IMM:
            begin
                e_wr = 1'b1;
                if (!i_ok)
                begin
                    e_err = ERR_INSN;
                end
            end
            OP_LOAD:
            begin
                e_wr  = 1'b1;
                e_cls = CLS_LOAD;
                if (f3 > F3_WORD)
                begin
                    e_err = ERR_INSN;
                end
                else if (!in_rng)
                begin
                    e_err = ERR_READ;
                end
            end
            OP_STORE:
            begin
                e_cls = CLS_STORE;
                if (f3 > F3_WORD)
                begin
                    e_err = ERR_INSN;
                end
                else if (!in_rng)
                begin
                    e_err = ERR_WRITE;
                end
            end
            OP_BRANCH:
            begin
                if (f3 == F3_BEQ)
                begin
                    if (a == b)
                    begin
                        e_npc = pc_reg + imm_b;
                    end
                end
                else if (f3 == F3_BNE)
                begin
                    if (a != b)
                    begin
                        e_npc = pc_reg + imm_b;
                    end
                end
                else
                begin
                    e_err = ERR_INSN;
                end
            end
            OP_JAL:
            begin
                e_wr  = 1'b1;
                e_val = pc_reg + 32'd4;
                e_npc = pc_reg + imm_j;
            end
            OP_LUI:
            begin
                e_wr  = 1'b1;
                e_val = {ir_reg[31:12], 12'd0};
            end
            OP_SYS:
            begin
                if (a == SYS_PRINT)
                begin
                    e_pv = 1'b1;
                end
                else if (a == SYS_EXIT)
                begin
                    e_halt = 1'b1;
                end
                else
                begin
                    e_err = ERR_ECALL;
                end
            end
            default:
            begin
                e_err = ERR_INSN;
            end
        endcase
    end

    // Execute results
    logic [31:0]        val_reg;
    logic [31:0]        npc_reg;
    logic [2:0]         err_reg;
    logic               halt_reg;
    logic               pv_reg;
    logic               wr_reg;
    logic [31:0]        addr_reg;
    logic signed [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_ir)
        begin
            ir_reg <= instruction_word;
        end
        if (cmd.exec)
        begin
            val_reg  <= e_val;
            npc_reg  <= e_npc;
            err_reg  <= e_err;
            halt_reg <= e_halt;
            pv_reg   <= e_pv;
            wr_reg   <= e_wr;
            addr_reg <= mem_addr;
            prod_reg <= $signed(a) * $signed(b);
        end
    end

    // Divider
    logic [31:0] div_q;
    logic [31:0] div_r;
    logic        div_done;

    rvx_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (a),
        .divisor   (b),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // Data memory, one byte per cycle, plus the clearing pass after reset
    logic [7:0]          dmem [MEMORY_BYTES];
    logic [AW-1:0]       clr_cnt_reg;
    logic                clr_busy_reg;
    logic [1:0]          cnt_reg;
    logic [3:0][7:0]     ld_reg;
    logic [AW-1:0]       maddr;
    logic [7:0]          st_byte;
    logic                is_store;

    assign maddr    = addr_reg[AW-1:0] + AW'(cnt_reg);
    assign st_byte  = b[{cnt_reg, 3'b000} +: 8];
    assign is_store = (op == OP_STORE);

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            dmem[clr_cnt_reg] <= 8'd0;
        end
        else if (cmd.mem_step && is_store)
        begin
            dmem[maddr] <= st_byte;
        end
        if (cmd.mem_step && !is_store)
        begin
            ld_reg[cnt_reg] <= dmem[maddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cmd.exec)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.mem_step)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    // Write-back value
    logic [31:0] ld_val;

    always_comb
    begin
        unique case (f3)
            F3_BYTE: ld_val = {{24{ld_reg[0][7]}}, ld_reg[0]};
            F3_HALF: ld_val = {{16{ld_reg[1][7]}}, ld_reg[1], ld_reg[0]};
            default: ld_val = ld_reg;
        endcase
    end

    always_comb
    begin
        unique case (e_cls)
            CLS_MUL:   wval = (f3 == F3_MUL) ? prod_reg[31:0] : prod_reg[63:32];
            CLS_DIV:
            begin
                if (f3 == F3_DIV)
                begin
                    wval = (b == 32'd0) ? 32'hFFFF_FFFF : div_q;
                end
                else
                begin
                    wval = (b == 32'd0) ? a : div_r;
                end
            end
            CLS_LOAD:  wval = ld_val;
            default:   wval = val_reg;
        endcase
    end

    logic fail;

    assign fail = (err_reg != ERR_NONE) || halt_reg;
    assign wen  = cmd.commit && !stopped_reg && !fail && wr_reg && (rd != REG_ZERO);

    // Commit and result register
    logic [31:0] o_npc_reg;
    logic        o_pv_reg;
    logic [31:0] o_pval_reg;
    logic        o_halt_reg;
    logic [2:0]  o_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            stopped_reg <= 1'b0;
        end
        else if (cmd.commit && !stopped_reg)
        begin
            if (fail)
            begin
                stopped_reg <= 1'b1;
            end
            else
            begin
                pc_reg <= npc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (stopped_reg)
            begin
                o_npc_reg  <= pc_reg;
                o_pv_reg   <= 1'b0;
                o_pval_reg <= 32'd0;
                o_halt_reg <= 1'b1;
                o_err_reg  <= ERR_NONE;
            end
            else if (fail)
            begin
                o_npc_reg  <= pc_reg;
                o_pv_reg   <= 1'b0;
                o_pval_reg <= 32'd0;
                o_halt_reg <= 1'b1;
                o_err_reg  <= err_reg;
            end
            else
            begin
                o_npc_reg  <= npc_reg;
                o_pv_reg   <= pv_reg;
                o_pval_reg <= pv_reg ? b : 32'd0;
                o_halt_reg <= 1'b0;
                o_err_reg  <= ERR_NONE;
            end
        end
    end

    assign next_pc     = o_npc_reg;
    assign print_valid = o_pv_reg;
    assign print_value = $signed(o_pval_reg);
    assign halted      = o_halt_reg;
    assign error_code  = o_err_reg;

    assign sts.clear_busy = clr_busy_reg;
    assign sts.stopped    = stopped_reg;
    assign sts.cls        = e_cls;
    assign sts.exec_err   = (e_err != ERR_NONE);
    assign sts.mem_last   = ({1'b0, cnt_reg} == (mem_len - 3'd1));
    assign sts.div_done   = div_done;

endmodule

/* hdl/rvx_ctrl.sv */
// ----------------------------------------------------------------------------
// rvx_ctrl
// Controller state machine: sequences read, execute, multi-cycle units and
// commit, and runs both handshakes.
// ----------------------------------------------------------------------------
module rvx_ctrl
    import rvx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MEM  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       can_commit;

    assign in_stall   = !((state_reg == S_IDLE) && !sts.clear_busy);
    assign accept     = in_valid && !in_stall;
    // The result register is free unless it still holds an untaken result.
    assign can_commit = !(out_valid_reg && out_stall);

    always_comb
    begin
        state_next    = state_reg;
        cmd.load_ir   = 1'b0;
        cmd.exec      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.mem_step  = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_ir = 1'b1;
                    state_next  = sts.stopped ? S_FIN : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.exec_err)
                begin
                    state_next = S_FIN;
                end
                else if (sts.cls == CLS_DIV)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if ((sts.cls == CLS_LOAD) || (sts.cls == CLS_STORE))
                begin
                    state_next = S_MEM;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_MEM:
            begin
                cmd.mem_step = 1'b1;
                if (sts.mem_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (can_commit)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/rv32im_subset_execute.sv */
// ----------------------------------------------------------------------------
// rv32im_subset_execute
// Multi-cycle executor for an RV32IM subset with register file, PC and
// byte-addressed data memory.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, instruction_word) takes one
// instruction per transaction; the output channel (out_valid, out_stall and
// the result fields) returns exactly one result per instruction, in order.
// One instruction is in flight at a time. The result register loads when the
// instruction commits, after the read and execute steps; loads and stores add
// one memory step per byte (single-byte memory port), div/rem wait for the
// radix-2 divider (one quotient bit per cycle), and once halted the block goes
// straight to commit. The next instruction is accepted in the cycle after that.
// A finished result waits in the output register while the next instruction
// is accepted; if the receiver stalls, the block holds in its commit cycle
// until that register is taken.
// After reset, in_stall stays high while the data memory is cleared one byte
// per cycle. Registers and PC start at zero.
// ----------------------------------------------------------------------------
module rv32im_subset_execute
    import rvx_pkg::*;
#(
    parameter int MEMORY_BYTES = MEM_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        instruction_word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        next_pc,
    output logic               print_valid,
    output logic signed [31:0] print_value,
    output logic               halted,
    output logic [2:0]         error_code
);

    cmd_t cmd;
    sts_t sts;

    rvx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    rvx_dpath #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .instruction_word (instruction_word),
        .next_pc          (next_pc),
        .print_valid      (print_valid),
        .print_value      (print_value),
        .halted           (halted),
        .error_code       (error_code)
    );

endmodule

/* hdl/rvx_checker.sv */
// ----------------------------------------------------------------------------
// rvx_checker
// Port-level checks for the RV32IM subset execute block, bound to the top.
// ----------------------------------------------------------------------------
module rvx_checker
    import rvx_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [31:0]        instruction_word,
    input logic               out_valid,
    input logic               out_stall,
    input logic [31:0]        next_pc,
    input logic               print_valid,
    input logic signed [31:0] print_value,
    input logic               halted,
    input logic [2:0]         error_code
);

    logic [1:0] pend_reg;
    logic       seen_halt_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Count of accepted instructions whose results are not yet taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            seen_halt_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc && halted)
            begin
                seen_halt_reg <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(halted)
                                   && $stable(error_code))
        else $error("result changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without an accepted instruction");

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !halted |-> error_code == ERR_NONE)
        else $error("error reported without halt");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_halt_reg |-> halted && !print_valid && error_code == ERR_NONE)
        else $error("machine ran after halt");

    a_print_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && print_valid |-> !halted)
        else $error("print on halted result");

endmodule

bind rv32im_subset_execute rvx_checker u_rvx_checker (.*);
